/* sv/rect_list_clip_cache_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the clip unit
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef RECT_LIST_CLIP_CACHE_MACROS_SVH
`define RECT_LIST_CLIP_CACHE_MACROS_SVH

// same-cycle implication
`define RLCC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("clip unit check failed");

// next-cycle implication
`define RLCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("clip unit check failed");

`endif

/* sv/rlcc_pkg.sv */
// ----------------------------------------------------------------------------
// Clip unit package
// Command codes, verdict codes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rlcc_pkg;
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_COMMIT = 2'd1;
    localparam logic [1:0] CMD_POINT  = 2'd2;
    localparam logic [1:0] CMD_AREA   = 2'd3;

    localparam logic [1:0] VERDICT_INVISIBLE = 2'd0;
    localparam logic [1:0] VERDICT_VISIBLE   = 2'd1;
    localparam logic [1:0] VERDICT_PARTIAL   = 2'd2;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam int DIM_BITS = 15;
    localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RST  = 15'd640;
    localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RST = 15'd480;
endpackage

/* sv/rlcc_if.sv */
// ----------------------------------------------------------------------------
// Clip unit channels
// Command channel and result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rlcc_cmd_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic [3:0]                   rect_index;
    logic [4:0]                   rect_count;
    logic signed [COORD_BITS-1:0] rect_left;
    logic signed [COORD_BITS-1:0] rect_top;
    logic signed [COORD_BITS-1:0] rect_right;
    logic signed [COORD_BITS-1:0] rect_bottom;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;

    modport source (output valid, command, rect_index, rect_count, rect_left, rect_top,
                    rect_right, rect_bottom, first_x, first_y, second_x, second_y,
                    input ready);
    modport sink (input valid, command, rect_index, rect_count, rect_left, rect_top,
                  rect_right, rect_bottom, first_x, first_y, second_x, second_y,
                  output ready);
endinterface

interface rlcc_res_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   verdict;
    logic signed [COORD_BITS-1:0] cache_min_x;
    logic signed [COORD_BITS-1:0] cache_min_y;
    logic signed [COORD_BITS-1:0] cache_max_x;
    logic signed [COORD_BITS-1:0] cache_max_y;
    logic                         cursor_check;

    modport source (output valid, verdict, cache_min_x, cache_min_y, cache_max_x,
                    cache_max_y, cursor_check, input ready);
    modport sink (input valid, verdict, cache_min_x, cache_min_y, cache_max_x,
                  cache_max_y, cursor_check, output ready);
endinterface

/* sv/rlcc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rlcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* sv/rlcc_out_stage.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one finished transaction until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rlcc_out_stage #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [WIDTH-1:0] load_data,
    output logic             free,
    output logic             valid,
    input  logic             ready,
    output logic [WIDTH-1:0] data
);
    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load && free)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            data_reg <= load_data;
        end
    end
endmodule

/* sv/rect_list_clip_cache.sv */
// ----------------------------------------------------------------------------
// Clip rectangle list with cached point test
// Rectangle table in RAM, cached clip rectangle, sequencer and result register.
// ----------------------------------------------------------------------------
// One command in flight at a time. A point that hits the cache or is off
// screen skips the table. A cache miss scans the table through its one read
// port, one rectangle a cycle, then on a miss of every rectangle runs a
// second pass to shrink the cache; an area command then also tests its second
// point. A finished result waits in the output register while the next
// command is taken.
`timescale 1ns / 1ps
module rect_list_clip_cache
    import rlcc_pkg::*;
#(
    parameter int MAX_RECTS  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [DIM_BITS-1:0] cfg_data,
    rlcc_cmd_if.sink            item_in,
    rlcc_res_if.source          result_out
);
    localparam int CB   = COORD_BITS;
    localparam int CW   = (CB > DIM_BITS ? CB : DIM_BITS + 1) + 1;
    localparam int IW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNTW = $clog2(MAX_RECTS + 1);
    localparam int RW   = 4 * CB;
    localparam int OW   = 2 + 4 * CB + 1;
    localparam logic signed [CW-1:0] CMIN_C = {{(CW-CB+1){1'b1}}, {(CB-1){1'b0}}};
    localparam logic signed [CW-1:0] CMAX_C = {{(CW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [CW-1:0] ONE_C  = CW'(1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CMT_RD = 8'b0000_0010,
        S_CMT    = 8'b0000_0100,
        S_TEST   = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_SHRINK = 8'b0010_0000,
        S_AREA   = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    function automatic logic signed [CW-1:0] ext(input logic [CB-1:0] v);
        ext = $signed({{(CW-CB){v[CB-1]}}, v});
    endfunction

    function automatic logic [CB-1:0] sat(input logic signed [CW-1:0] v);
        if (v < CMIN_C)
            sat = CMIN_C[CB-1:0];
        else if (v > CMAX_C)
            sat = CMAX_C[CB-1:0];
        else
            sat = v[CB-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [DIM_BITS-1:0]   width_reg, height_reg;
    logic [CNTW-1:0]       count_reg;
    logic [CNTW-1:0]       idx_reg;
    logic [1:0]            cmd_reg;
    logic signed [CW-1:0]  x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [CW-1:0]  cminx_reg, cminy_reg, cmaxx_reg, cmaxy_reg;
    logic                  plot_reg;
    logic                  cursor_reg;
    logic [1:0]            verdict_reg;

    logic                  accept;
    logic                  wr_en;
    logic [IW-1:0]         rd_addr;
    logic [RW-1:0]         rd_data;
    logic signed [CW-1:0]  ql, qt, qr, qb, qr1, qb1;
    logic                  hit1, hit2, contains, last;
    logic signed [CW-1:0]  w_s, h_s;
    logic [CNTW-1:0]       idx_inc;
    logic                  out_free;
    logic [OW-1:0]         out_data;

    assign accept         = item_in.valid && item_in.ready;
    assign item_in.ready  = (state_reg == S_IDLE);
    assign wr_en          = accept && (item_in.command == CMD_LOAD)
                            && (int'(item_in.rect_index) < MAX_RECTS);

    assign ql  = ext(rd_data[4*CB-1:3*CB]);
    assign qt  = ext(rd_data[3*CB-1:2*CB]);
    assign qr  = ext(rd_data[2*CB-1:CB]);
    assign qb  = ext(rd_data[CB-1:0]);
    assign qr1 = qr - ONE_C;
    assign qb1 = qb - ONE_C;
    assign w_s = CW'(width_reg);
    assign h_s = CW'(height_reg);

    assign hit1 = x1_reg >= cminx_reg && x1_reg <= cmaxx_reg
                  && y1_reg >= cminy_reg && y1_reg <= cmaxy_reg;
    assign hit2 = x2_reg >= cminx_reg && x2_reg <= cmaxx_reg
                  && y2_reg >= cminy_reg && y2_reg <= cmaxy_reg;
    assign contains = x1_reg >= ql && y1_reg >= qt && x1_reg < qr && y1_reg < qb;
    assign idx_inc  = idx_reg + CNTW'(1);
    assign last     = (idx_inc == count_reg);

    always_comb
    begin
        if ((state_reg == S_SCAN && !last) || (state_reg == S_SHRINK))
            rd_addr = idx_inc[IW-1:0];
        else
            rd_addr = '0;
    end

    rlcc_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS), .AW(IW)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IW'(item_in.rect_index)),
        .wr_data ({item_in.rect_left, item_in.rect_top,
                   item_in.rect_right, item_in.rect_bottom}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item_in.command)
                        CMD_LOAD:   state_next = S_FIN;
                        CMD_COMMIT: state_next = (item_in.rect_count == 5'd0) ? S_FIN
                                                                              : S_CMT_RD;
                        default:    state_next = S_TEST;
                    endcase
                end
            end
            S_CMT_RD: state_next = S_CMT;
            S_CMT:    state_next = S_FIN;
            S_TEST:
            begin
                if (hit1 || x1_reg < 0 || y1_reg < 0 || x1_reg >= w_s || y1_reg >= h_s
                    || count_reg == '0)
                    state_next = (cmd_reg == CMD_AREA) ? S_AREA : S_FIN;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (contains)
                    state_next = (cmd_reg == CMD_AREA) ? S_AREA : S_FIN;
                else if (last)
                    state_next = S_SHRINK;
            end
            S_SHRINK:
            begin
                if (last)
                    state_next = (cmd_reg == CMD_AREA) ? S_AREA : S_FIN;
            end
            S_AREA: state_next = S_FIN;
            S_FIN:  state_next = out_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            cminx_reg   <= CMIN_C;
            cminy_reg   <= CMIN_C;
            cmaxx_reg   <= CMAX_C;
            cmaxy_reg   <= CMAX_C;
            plot_reg    <= 1'b0;
            cursor_reg  <= 1'b0;
            verdict_reg <= VERDICT_INVISIBLE;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cursor_reg  <= 1'b0;
                        verdict_reg <= plot_reg ? VERDICT_VISIBLE : VERDICT_INVISIBLE;
                        idx_reg     <= '0;
                        if (item_in.command == CMD_COMMIT)
                        begin
                            if (int'(item_in.rect_count) > MAX_RECTS)
                                count_reg <= CNTW'(MAX_RECTS);
                            else
                                count_reg <= CNTW'(item_in.rect_count);
                            if (item_in.rect_count == 5'd0)
                            begin
                                cminx_reg   <= CMIN_C;
                                cminy_reg   <= CMIN_C;
                                cmaxx_reg   <= CMAX_C;
                                cmaxy_reg   <= CMAX_C;
                                plot_reg    <= 1'b0;
                                verdict_reg <= VERDICT_INVISIBLE;
                            end
                        end
                    end
                end
                S_CMT:
                begin
                    cminx_reg   <= ql;
                    cminy_reg   <= qt;
                    cmaxx_reg   <= qr1;
                    cmaxy_reg   <= qb1;
                    plot_reg    <= 1'b1;
                    verdict_reg <= VERDICT_VISIBLE;
                end
                S_TEST:
                begin
                    priority if (hit1)
                    begin
                        verdict_reg <= plot_reg ? VERDICT_VISIBLE : VERDICT_INVISIBLE;
                        cursor_reg  <= plot_reg && (cmd_reg == CMD_POINT);
                    end
                    else if (x1_reg < 0)
                    begin
                        cminx_reg <= CMIN_C; cminy_reg <= CMIN_C;
                        cmaxx_reg <= -ONE_C; cmaxy_reg <= CMAX_C;
                        plot_reg  <= 1'b0;   verdict_reg <= VERDICT_INVISIBLE;
                    end
                    else if (y1_reg < 0)
                    begin
                        cminx_reg <= CMIN_C; cminy_reg <= CMIN_C;
                        cmaxx_reg <= CMAX_C; cmaxy_reg <= -ONE_C;
                        plot_reg  <= 1'b0;   verdict_reg <= VERDICT_INVISIBLE;
                    end
                    else if (x1_reg >= w_s)
                    begin
                        cminx_reg <= w_s;    cminy_reg <= CMIN_C;
                        cmaxx_reg <= CMAX_C; cmaxy_reg <= CMAX_C;
                        plot_reg  <= 1'b0;   verdict_reg <= VERDICT_INVISIBLE;
                    end
                    else if (y1_reg >= h_s)
                    begin
                        cminx_reg <= CMIN_C; cminy_reg <= h_s;
                        cmaxx_reg <= CMAX_C; cmaxy_reg <= CMAX_C;
                        plot_reg  <= 1'b0;   verdict_reg <= VERDICT_INVISIBLE;
                    end
                    else if (count_reg == '0)
                    begin
                        cminx_reg   <= '0;            cminy_reg <= '0;
                        cmaxx_reg   <= w_s - ONE_C;   cmaxy_reg <= h_s - ONE_C;
                        plot_reg    <= 1'b1;          cursor_reg <= 1'b1;
                        verdict_reg <= VERDICT_VISIBLE;
                    end
                    else
                    begin
                        idx_reg <= '0;
                    end
                end
                S_SCAN:
                begin
                    priority if (contains)
                    begin
                        cminx_reg   <= ql;   cminy_reg <= qt;
                        cmaxx_reg   <= qr1;  cmaxy_reg <= qb1;
                        plot_reg    <= 1'b1; cursor_reg <= 1'b1;
                        verdict_reg <= VERDICT_VISIBLE;
                    end
                    else if (last)
                    begin
                        cminx_reg   <= CMIN_C; cminy_reg <= CMIN_C;
                        cmaxx_reg   <= CMAX_C; cmaxy_reg <= CMAX_C;
                        plot_reg    <= 1'b0;   idx_reg   <= '0;
                        verdict_reg <= VERDICT_INVISIBLE;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_SHRINK:
                begin
                    if (x1_reg < ql && ql <= cmaxx_reg)
                        cmaxx_reg <= ql - ONE_C;
                    if (x1_reg > qr1 && qr1 >= cminx_reg)
                        cminx_reg <= qr;
                    if (y1_reg < qt && qt <= cmaxy_reg)
                        cmaxy_reg <= qt - ONE_C;
                    if (y1_reg > qb1 && qb1 >= cminy_reg)
                        cminy_reg <= qb;
                    idx_reg <= idx_inc;
                end
                S_AREA:
                begin
                    if (hit2)
                    begin
                        verdict_reg <= plot_reg ? VERDICT_VISIBLE : VERDICT_INVISIBLE;
                        if (plot_reg)
                            cursor_reg <= 1'b1;
                    end
                    else
                    begin
                        verdict_reg <= VERDICT_PARTIAL;
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= item_in.command;
            x1_reg  <= ext(item_in.first_x);
            y1_reg  <= ext(item_in.first_y);
            x2_reg  <= ext(item_in.second_x);
            y2_reg  <= ext(item_in.second_y);
        end
    end

    rlcc_out_stage #(.WIDTH(OW)) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (state_reg == S_FIN),
        .load_data ({verdict_reg, sat(cminx_reg), sat(cminy_reg),
                     sat(cmaxx_reg), sat(cmaxy_reg), cursor_reg}),
        .free      (out_free),
        .valid     (result_out.valid),
        .ready     (result_out.ready),
        .data      (out_data)
    );

    assign result_out.verdict      = out_data[OW-1:OW-2];
    assign result_out.cache_min_x  = out_data[4*CB:3*CB+1];
    assign result_out.cache_min_y  = out_data[3*CB:2*CB+1];
    assign result_out.cache_max_x  = out_data[2*CB:CB+1];
    assign result_out.cache_max_y  = out_data[CB:1];
    assign result_out.cursor_check = out_data[0];
endmodule

/* sv/rlcc_checker.sv */
// ----------------------------------------------------------------------------
// Clip unit port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rect_list_clip_cache_macros.svh"
module rlcc_checker
    import rlcc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] verdict
);
    `RLCC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    `RLCC_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid)
    `RLCC_ASSERT_NOW(a_verdict_code, clk, rst_n, out_valid,
        verdict == VERDICT_INVISIBLE || verdict == VERDICT_VISIBLE || verdict == VERDICT_PARTIAL)
endmodule

bind rect_list_clip_cache rlcc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .verdict   (result_out.verdict)
);
